[sv/mrcc_pkg.sv]
// Shared types, constants and the CRC table function for the Modbus RTU frame checker.
`default_nettype none

package mrcc_pkg;

  localparam logic       CMD_REQUEST  = 1'b0;
  localparam logic       CMD_REPLY    = 1'b1;

  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_SHORT     = 2'd1;
  localparam logic [1:0] VERDICT_CRC_BAD   = 2'd2;
  localparam logic [1:0] VERDICT_MISMATCH  = 2'd3;

  localparam logic [7:0]  CRC_PRESET = 8'hFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam int          MIN_LEN    = 5;

  // Register index of the slave address, taken from the word address.
  localparam logic REG_SLAVE_ADDR = 1'b0;

  // One job handed from the front to the back; it expands into one to three results.
  typedef struct packed {
    logic       is_verdict;
    logic [1:0] verdict;
    logic       echo_en;
    logic       crc_en;
    logic [7:0] echo_byte;
    logic [7:0] crc_hi;
    logic [7:0] crc_lo;
  } job_t;

  // Entry of the reflected 0xA001 table; an XOR network in hardware.
  function automatic logic [15:0] crc_entry(input logic [7:0] idx);
    logic [15:0] t;
    t = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      if (t[0]) begin
        t = (t >> 1) ^ CRC_POLY;
      end else begin
        t = t >> 1;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[sv/mrcc_front.sv]
// Front end: accepts frame bytes, keeps the CRC and frame state, and builds result jobs.
`default_nettype none

module mrcc_front import mrcc_pkg::*; #(
  parameter int FRAME_MAX = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic [7:0] slave_address,
  input  wire logic       q_full,
  output logic            push,
  output job_t            job
);

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_MAX);

  logic [7:0]       crc_hi_r, crc_hi_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       dly_old_r, dly_old_nxt;
  logic [7:0]       dly_new_r, dly_new_nxt;
  logic [7:0]       rep_addr_r, rep_addr_nxt;
  logic [7:0]       rep_func_r, rep_func_nxt;
  logic [7:0]       exp_func_r, exp_func_nxt;

  logic             accept;
  logic             keep;
  logic             is_req;
  logic             feed_en;
  logic [7:0]       feed_byte;
  logic [15:0]      tab;
  logic [7:0]       crc_hi_upd, crc_lo_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [7:0]       dly_old_upd, dly_new_upd;
  logic [1:0]       verdict;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign is_req   = (in_cmd == CMD_REQUEST);
  assign keep     = cnt_r < CNT_MAX;

  // Reply bytes reach the CRC two bytes late, so the CRC never covers the trailer.
  assign feed_byte = is_req ? in_data_byte : dly_old_r;
  assign feed_en   = keep && (is_req || cnt_r >= CNT_W'(2));
  assign tab       = crc_entry(crc_hi_r ^ feed_byte);

  always_comb begin
    crc_hi_upd  = crc_hi_r;
    crc_lo_upd  = crc_lo_r;
    cnt_upd     = cnt_r;
    dly_old_upd = dly_old_r;
    dly_new_upd = dly_new_r;
    rep_addr_nxt = rep_addr_r;
    rep_func_nxt = rep_func_r;
    exp_func_nxt = exp_func_r;
    if (feed_en) begin
      crc_hi_upd = crc_lo_r ^ tab[7:0];
      crc_lo_upd = tab[15:8];
    end
    if (keep) begin
      cnt_upd = cnt_r + CNT_W'(1);
      if (is_req) begin
        if (cnt_r == CNT_W'(1)) begin
          exp_func_nxt = in_data_byte;
        end
      end else begin
        if (cnt_r == '0) begin
          rep_addr_nxt = in_data_byte;
        end else if (cnt_r == CNT_W'(1)) begin
          rep_func_nxt = in_data_byte;
        end
        dly_old_upd = dly_new_r;
        dly_new_upd = in_data_byte;
      end
    end
  end

  always_comb begin
    priority if (cnt_upd < CNT_W'(MIN_LEN)) begin
      verdict = VERDICT_SHORT;
    end else if (crc_hi_upd != dly_old_upd || crc_lo_upd != dly_new_upd) begin
      verdict = VERDICT_CRC_BAD;
    end else if (rep_addr_nxt != slave_address || rep_func_nxt != exp_func_r) begin
      verdict = VERDICT_MISMATCH;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    if (in_last_byte) begin
      crc_hi_nxt  = CRC_PRESET;
      crc_lo_nxt  = CRC_PRESET;
      cnt_nxt     = '0;
      dly_old_nxt = '0;
      dly_new_nxt = '0;
    end else begin
      crc_hi_nxt  = crc_hi_upd;
      crc_lo_nxt  = crc_lo_upd;
      cnt_nxt     = cnt_upd;
      dly_old_nxt = dly_old_upd;
      dly_new_nxt = dly_new_upd;
    end
  end

  assign push = accept && (is_req ? (keep || in_last_byte) : in_last_byte);

  always_comb begin
    job.is_verdict = !is_req;
    job.verdict    = verdict;
    job.echo_en    = is_req && keep;
    job.crc_en     = is_req && in_last_byte;
    job.echo_byte  = in_data_byte;
    job.crc_hi     = crc_hi_upd;
    job.crc_lo     = crc_lo_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_hi_r   <= CRC_PRESET;
      crc_lo_r   <= CRC_PRESET;
      cnt_r      <= '0;
      dly_old_r  <= '0;
      dly_new_r  <= '0;
      rep_addr_r <= '0;
      rep_func_r <= '0;
      exp_func_r <= '0;
    end else if (accept) begin
      crc_hi_r   <= crc_hi_nxt;
      crc_lo_r   <= crc_lo_nxt;
      cnt_r      <= cnt_nxt;
      dly_old_r  <= dly_old_nxt;
      dly_new_r  <= dly_new_nxt;
      rep_addr_r <= rep_addr_nxt;
      rep_func_r <= rep_func_nxt;
      exp_func_r <= exp_func_nxt;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("frame byte count exceeds the buffer size");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> cnt_r == '0 && crc_hi_r == CRC_PRESET && crc_lo_r == CRC_PRESET)
    else $error("frame state not cleared after the last byte");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

`default_nettype wire

[sv/mrcc_queue.sv]
// Short job queue between the front end and the result sequencer.
`default_nettype none

module mrcc_queue import mrcc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

[sv/mrcc_back.sv]
// Result sequencer: expands each queued job into its results behind an output register.
`default_nettype none

module mrcc_back import mrcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  job_t      head_job,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic       out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_end_of_run,
  output logic [1:0] out_verdict
);

  logic       valid_r, valid_nxt;
  logic [1:0] seq_r, seq_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       end_r, end_nxt;
  logic [1:0] verdict_r, verdict_nxt;

  logic       load, take;
  logic [1:0] n_res;
  logic       last_of_job;
  logic       at_crc_hi;

  assign load = !valid_r || out_ready;
  assign take = load && !q_empty;

  // A request job is an optional echo byte followed by an optional CRC pair.
  assign n_res = head_job.is_verdict ? 2'd1
               : ({1'b0, head_job.echo_en} + (head_job.crc_en ? 2'd2 : 2'd0));
  assign last_of_job = (seq_r == n_res - 2'd1);
  assign at_crc_hi   = (seq_r == {1'b0, head_job.echo_en});
  assign pop         = take && last_of_job;

  always_comb begin
    valid_nxt   = valid_r;
    seq_nxt     = seq_r;
    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    verdict_nxt = verdict_r;
    if (take) begin
      valid_nxt = 1'b1;
      seq_nxt   = last_of_job ? 2'd0 : seq_r + 2'd1;
      if (head_job.is_verdict) begin
        kind_nxt    = KIND_VERDICT;
        byte_nxt    = 8'h00;
        end_nxt     = 1'b1;
        verdict_nxt = head_job.verdict;
      end else begin
        kind_nxt    = KIND_BYTE;
        verdict_nxt = VERDICT_OK;
        if (head_job.echo_en && seq_r == 2'd0) begin
          byte_nxt = head_job.echo_byte;
          end_nxt  = !head_job.crc_en;
        end else if (at_crc_hi) begin
          byte_nxt = head_job.crc_hi;
          end_nxt  = 1'b0;
        end else begin
          byte_nxt = head_job.crc_lo;
          end_nxt  = 1'b1;
        end
      end
    end else if (load) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seq_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    end_r     <= end_nxt;
    verdict_r <= verdict_nxt;
  end

  assign out_valid      = valid_r;
  assign out_kind       = kind_r;
  assign out_out_byte   = byte_r;
  assign out_end_of_run = end_r;
  assign out_verdict    = verdict_r;

  a_seq_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> seq_r < n_res)
    else $error("result index runs past the end of its job");

  a_seq_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> seq_r == 2'd0)
    else $error("result index left nonzero with no job pending");

endmodule

`default_nettype wire

[sv/modbus_rtu_frame_crc_checker_core.sv]
// A result passes through the job queue and then the output register to out_valid.
// Throughput: one input byte per cycle while the queue has room; results leave one
// per cycle through the output register while out_ready is high. The job queue
// (QUEUE_DEPTH entries) absorbs output stalls and a request's final echo and CRC pair.
// Reset: synchronous on rst_n low; CRC preset, counters, queue and the slave
// address register (to 1) are set directly, with no clearing pass.
`default_nettype none

module modbus_rtu_frame_crc_checker_core import mrcc_pkg::*; #(
  parameter int FRAME_MAX   = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_out_byte,
  output logic             out_end_of_run,
  output logic [1:0]       out_verdict,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] slave_addr_r, slave_addr_nxt;
  logic       cfg_wr;
  logic       reg_sel;

  logic q_full, q_empty;
  logic push, pop;
  job_t push_job, head_job;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SLAVE_ADDR);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {24'h000000, slave_addr_r} : 32'h00000000;

  assign slave_addr_nxt = cfg_wr ? pwdata[7:0] : slave_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h01;
    end else begin
      slave_addr_r <= slave_addr_nxt;
    end
  end

  mrcc_front #(
    .FRAME_MAX(FRAME_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .slave_address(slave_addr_r),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  mrcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  mrcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_out_byte  (out_out_byte),
    .out_end_of_run(out_end_of_run),
    .out_verdict   (out_verdict)
  );

endmodule

`default_nettype wire
